### rtl/phlc_pkg.sv
// Package for the phone line call controller: codes, widths and reset values.
// Used by phone_line_call_controller and its checker; no dependencies.
package phlc_pkg;

    localparam int CFG_W          = 6;
    localparam int CFG_IDX_W      = 2;
    localparam int CNT_W          = 6;
    localparam int READ_COUNT_CAP = 50;

    localparam logic [CFG_W-1:0] RING_ON_RESET  = 6'd5;
    localparam logic [CFG_W-1:0] RING_PER_RESET = 6'd12;
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 6'd3;

    typedef enum logic [1:0] {
        CFG_RING_ON  = 2'd0,
        CFG_RING_PER = 2'd1,
        CFG_DEBOUNCE = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        FUNC_TICK        = 2'd0,
        FUNC_INCOMING    = 2'd1,
        FUNC_ESTABLISHED = 2'd2,
        FUNC_CLOSED      = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_RINGING = 2'd1,
        ST_INCALL  = 2'd2
    } line_state_t;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_ACCEPT = 2'd1,
        CMD_HANGUP = 2'd2,
        CMD_DIAL   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        LED_OFF   = 2'd0,
        LED_SOLID = 2'd1,
        LED_BLINK = 2'd2
    } led_t;

    localparam logic [1:0] HOOK_ON      = 2'd0;
    localparam logic [1:0] HOOK_OFF     = 2'd1;
    localparam logic [1:0] HOOK_UNKNOWN = 2'd2;

    localparam logic [1:0] CH_ONE = 2'd1;
    localparam logic [1:0] CH_TWO = 2'd2;

endpackage

### rtl/phone_line_call_controller.sv
// Top level of the two-jack phone line call controller.
// Depends on phlc_pkg for codes, widths and reset values.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | func, hook_pair_ok, hook_first_jack,
//          |                      | hook_second_jack, hook_single_ok, hook_single
//  out     | out_valid/ out_ready | ring_active, led_phone1_mode, led_phone2_mode,
//          |                      | command, channel_select, channel_strobe, call_state
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// One transaction per cycle sustained while out_ready is high.
// A transaction sits in the input register, then the update logic writes the
// line state and the result register together.
// rst_n clears the line state, debounce and config registers to their defaults.
// A stalled result holds while the input register still takes one more transaction.
module phone_line_call_controller (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic       hook_pair_ok,
    input  logic       hook_first_jack,
    input  logic       hook_second_jack,
    input  logic       hook_single_ok,
    input  logic       hook_single,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       ring_active,
    output logic [1:0] led_phone1_mode,
    output logic [1:0] led_phone2_mode,
    output logic [1:0] command,
    output logic [1:0] channel_select,
    output logic       channel_strobe,
    output logic [1:0] call_state
);

    localparam int CW = phlc_pkg::CFG_W;
    localparam int NW = phlc_pkg::CNT_W;

    // configuration
    logic [CW-1:0] ring_on_reg;
    logic [CW-1:0] ring_per_reg;
    logic [CW-1:0] debounce_reg;

    // input register
    logic       s1_valid_reg;
    logic [1:0] func_reg;
    logic       pair_ok_reg;
    logic       h1_reg;
    logic       h2_reg;
    logic       single_ok_reg;
    logic       single_reg;

    // line state
    phlc_pkg::line_state_t state_reg, state_next;
    logic [NW-1:0] cad_reg, cad_next;
    logic          ring_reg, ring_next;
    logic [1:0]    acc_hook_reg, acc_hook_next;
    logic [1:0]    cand_hook_reg, cand_hook_next;
    logic [NW-1:0] reads_reg, reads_next;
    logic          settled_reg, settled_next;
    logic [1:0]    chan_reg, chan_next;
    phlc_pkg::led_t led1_reg, led1_next;
    phlc_pkg::led_t led2_reg, led2_next;

    // result register
    logic           out_valid_reg;
    logic           ring_out_reg;
    phlc_pkg::led_t led1_out_reg;
    phlc_pkg::led_t led2_out_reg;
    phlc_pkg::cmd_t cmd_out_reg, cmd_next;
    logic [1:0]     chan_out_reg;
    logic           strobe_out_reg, strobe_next;
    phlc_pkg::line_state_t state_out_reg;

    logic advance;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    // LED of the channel-one jack is solid when channel two is answered, and vice versa
    function automatic phlc_pkg::led_t led_for(input logic [1:0] ch, input logic [1:0] jack);
        phlc_pkg::led_t m;
        m = (ch == jack) ? phlc_pkg::LED_SOLID : phlc_pkg::LED_OFF;
        return m;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_on_reg  <= phlc_pkg::RING_ON_RESET;
            ring_per_reg <= phlc_pkg::RING_PER_RESET;
            debounce_reg <= phlc_pkg::DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            case (phlc_pkg::cfg_idx_t'(cfg_index))
                phlc_pkg::CFG_RING_ON:  ring_on_reg  <= cfg_data;
                phlc_pkg::CFG_RING_PER: ring_per_reg <= cfg_data;
                phlc_pkg::CFG_DEBOUNCE: debounce_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic          ring_on_phase;
        logic          have;
        logic          hk;
        logic [1:0]    which;
        logic [NW:0]   cad_inc;

        state_next     = state_reg;
        cad_next       = cad_reg;
        ring_next      = ring_reg;
        acc_hook_next  = acc_hook_reg;
        cand_hook_next = cand_hook_reg;
        reads_next     = reads_reg;
        settled_next   = settled_reg;
        chan_next      = chan_reg;
        led1_next      = led1_reg;
        led2_next      = led2_reg;
        cmd_next       = phlc_pkg::CMD_NONE;
        strobe_next    = 1'b0;
        ring_on_phase  = 1'b0;
        have           = 1'b0;
        hk             = 1'b0;
        which          = chan_reg;
        cad_inc        = {1'b0, cad_reg} + 1'b1;

        case (phlc_pkg::func_t'(func_reg))
            phlc_pkg::FUNC_INCOMING:
            begin
                if (state_reg == phlc_pkg::ST_IDLE)
                begin
                    state_next = phlc_pkg::ST_RINGING;
                    cad_next   = '0;
                    led1_next  = phlc_pkg::LED_BLINK;
                    led2_next  = phlc_pkg::LED_BLINK;
                end
            end
            phlc_pkg::FUNC_ESTABLISHED:
            begin
                state_next = phlc_pkg::ST_INCALL;
                ring_next  = 1'b0;
                led1_next  = led_for(chan_reg, phlc_pkg::CH_TWO);
                led2_next  = led_for(chan_reg, phlc_pkg::CH_ONE);
            end
            phlc_pkg::FUNC_CLOSED:
            begin
                state_next = phlc_pkg::ST_IDLE;
                ring_next  = 1'b0;
                led1_next  = phlc_pkg::LED_OFF;
                led2_next  = phlc_pkg::LED_OFF;
                chan_next  = phlc_pkg::CH_TWO;
            end
            default:
            begin
                if (state_reg == phlc_pkg::ST_RINGING)
                begin
                    ring_on_phase = (cad_reg < ring_on_reg);
                    ring_next     = ring_on_phase;
                    cad_next      = (cad_inc >= {1'b0, ring_per_reg}) ? '0 : cad_inc[NW-1:0];
                end
                else
                begin
                    ring_next = 1'b0;
                    cad_next  = '0;
                end

                if (!ring_on_phase)
                begin
                    if (pair_ok_reg)
                    begin
                        have = 1'b1;
                        if (state_reg == phlc_pkg::ST_INCALL)
                        begin
                            hk = (chan_reg == phlc_pkg::CH_ONE) ? h1_reg : h2_reg;
                        end
                        else
                        begin
                            hk    = h1_reg | h2_reg;
                            which = h1_reg ? phlc_pkg::CH_ONE
                                  : (h2_reg ? phlc_pkg::CH_TWO : chan_reg);
                        end
                    end
                    else if (single_ok_reg)
                    begin
                        have = 1'b1;
                        hk   = single_reg;
                    end

                    if (have)
                    begin
                        if ({1'b0, hk} == cand_hook_reg)
                        begin
                            if (reads_reg < NW'(phlc_pkg::READ_COUNT_CAP))
                                reads_next = reads_reg + 1'b1;
                        end
                        else
                        begin
                            cand_hook_next = {1'b0, hk};
                            reads_next     = NW'(1);
                        end

                        if (reads_next == debounce_reg && cand_hook_next != acc_hook_reg)
                        begin
                            if (!settled_reg)
                            begin
                                settled_next = 1'b1;
                            end
                            else if (cand_hook_next == phlc_pkg::HOOK_OFF)
                            begin
                                if (state_reg == phlc_pkg::ST_INCALL)
                                begin
                                    led1_next = led_for(chan_reg, phlc_pkg::CH_TWO);
                                    led2_next = led_for(chan_reg, phlc_pkg::CH_ONE);
                                end
                                else
                                begin
                                    cmd_next    = (state_reg == phlc_pkg::ST_RINGING)
                                                ? phlc_pkg::CMD_ACCEPT : phlc_pkg::CMD_DIAL;
                                    chan_next   = which;
                                    strobe_next = 1'b1;
                                    led1_next   = led_for(which, phlc_pkg::CH_TWO);
                                    led2_next   = led_for(which, phlc_pkg::CH_ONE);
                                    if (state_reg == phlc_pkg::ST_RINGING)
                                        ring_next = 1'b0;
                                end
                            end
                            else
                            begin
                                led1_next = phlc_pkg::LED_OFF;
                                led2_next = phlc_pkg::LED_OFF;
                                if (state_reg != phlc_pkg::ST_IDLE)
                                begin
                                    cmd_next   = phlc_pkg::CMD_HANGUP;
                                    ring_next  = 1'b0;
                                    state_next = phlc_pkg::ST_IDLE;
                                    chan_next  = phlc_pkg::CH_TWO;
                                end
                            end
                            acc_hook_next = cand_hook_next;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= phlc_pkg::ST_IDLE;
            cad_reg       <= '0;
            ring_reg      <= 1'b0;
            acc_hook_reg  <= phlc_pkg::HOOK_UNKNOWN;
            cand_hook_reg <= phlc_pkg::HOOK_UNKNOWN;
            reads_reg     <= '0;
            settled_reg   <= 1'b0;
            chan_reg      <= phlc_pkg::CH_TWO;
            led1_reg      <= phlc_pkg::LED_OFF;
            led2_reg      <= phlc_pkg::LED_OFF;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                state_reg     <= state_next;
                cad_reg       <= cad_next;
                ring_reg      <= ring_next;
                acc_hook_reg  <= acc_hook_next;
                cand_hook_reg <= cand_hook_next;
                reads_reg     <= reads_next;
                settled_reg   <= settled_next;
                chan_reg      <= chan_next;
                led1_reg      <= led1_next;
                led2_reg      <= led2_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            func_reg      <= func;
            pair_ok_reg   <= hook_pair_ok;
            h1_reg        <= hook_first_jack;
            h2_reg        <= hook_second_jack;
            single_ok_reg <= hook_single_ok;
            single_reg    <= hook_single;
        end
        if (advance)
        begin
            ring_out_reg   <= ring_next;
            led1_out_reg   <= led1_next;
            led2_out_reg   <= led2_next;
            cmd_out_reg    <= cmd_next;
            chan_out_reg   <= chan_next;
            strobe_out_reg <= strobe_next;
            state_out_reg  <= state_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign ring_active     = ring_out_reg;
    assign led_phone1_mode = led1_out_reg;
    assign led_phone2_mode = led2_out_reg;
    assign command         = cmd_out_reg;
    assign channel_select  = chan_out_reg;
    assign channel_strobe  = strobe_out_reg;
    assign call_state      = state_out_reg;

endmodule

### rtl/phlc_checker.sv
// Port-level checker for phone_line_call_controller, bound to the top level.
// Depends on phlc_pkg for command, state and channel codes.
module phlc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       ring_active,
    input logic [1:0] led_phone1_mode,
    input logic [1:0] led_phone2_mode,
    input logic [1:0] command,
    input logic [1:0] channel_select,
    input logic       channel_strobe,
    input logic [1:0] call_state
);

    // result held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(command) && $stable(call_state)
            && $stable(channel_select) && $stable(led_phone1_mode))
        else $error("result changed while stalled");

    // ring drive only while ringing
    a_ring_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ring_active |-> call_state == phlc_pkg::ST_RINGING)
        else $error("ring on outside ringing state");

    // channel strobe only with accept or dial
    a_strobe_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && channel_strobe |->
            command == phlc_pkg::CMD_ACCEPT || command == phlc_pkg::CMD_DIAL)
        else $error("channel strobe without accept or dial");

    // hangup returns the line to idle on channel two with the ring and both LEDs off
    a_hangup: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command == phlc_pkg::CMD_HANGUP |->
            call_state == phlc_pkg::ST_IDLE && channel_select == phlc_pkg::CH_TWO
            && !ring_active && led_phone1_mode == phlc_pkg::LED_OFF
            && led_phone2_mode == phlc_pkg::LED_OFF)
        else $error("hangup result inconsistent");

    // accept keeps the line ringing with the ring voltage dropped
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command == phlc_pkg::CMD_ACCEPT |->
            call_state == phlc_pkg::ST_RINGING && !ring_active && channel_strobe)
        else $error("accept result inconsistent");

endmodule

bind phone_line_call_controller phlc_checker u_phlc_checker (.*);
